// ===== rtl/svm_pkg.sv =====
package svm_pkg;

   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 16;
   localparam int SAMPLE_W   = 16;
   localparam int LEN_W      = 17;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 5;
   localparam int COUNT_W    = 6;

   // Memory depth is at least 256 words, so an address quotient fits in 8 bits.
   localparam int QUOT_W      = 8;
   localparam int RECIP_SHIFT = ADDR_W + QUOT_W;
   localparam int MOD_STEPS   = 3;
   localparam int MOD_STEP_W  = 2;

   localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUEUE = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SLOT  = 2'd1,
      STAT_ZERO_LEN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_LOAD,
      S_SCAN,
      S_TICK_SMP,
      S_TICK_ACC,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/svm_if.sv =====
interface svm_req_if;
   import svm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic [ADDR_W-1:0]          address;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic [LEN_W-1:0]           sound_length;

   modport source (output valid, command, address, sample_value, sound_length, input ready);
   modport sink (input valid, command, address, sample_value, sound_length, output ready);
endinterface

interface svm_rsp_if;
   import svm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mixed_sample;
   logic [STATUS_W-1:0]        status;
   logic [SLOT_W-1:0]          voice_slot;
   logic [COUNT_W-1:0]         active_voices;

   modport source (output valid, mixed_sample, status, voice_slot, active_voices, input ready);
   modport sink (input valid, mixed_sample, status, voice_slot, active_voices, output ready);
endinterface

// ===== rtl/sample_voice_mixer_core.sv =====
// Load reduces the address modulo the memory depth, then writes the sample word; queue
// reduces it, then scans the slots from the first for a free one (no free slot or zero
// length: error status); tick adds up the active voices; command 3 goes straight to the response.
// One request at a time; the next is taken the cycle after the response is registered.
// The sequencer walks the voice-record and sample memories, one port each.
// Synchronous reset clears the voice flags and count; sample memory and voice records are not.
module sample_voice_mixer_core #(
   parameter int VOICE_COUNT  = 32,
   parameter int SAMPLE_WORDS = 65536
) (
   input logic       clock,
   input logic       reset,
   svm_req_if.sink   req_chan,
   svm_rsp_if.source rsp_chan
);
   import svm_pkg::*;

   localparam int AW  = $clog2(SAMPLE_WORDS);
   localparam int IW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int CW  = $clog2(VOICE_COUNT + 1);
   localparam int RW  = ADDR_W + QUOT_W;
   localparam int PW  = RECIP_SHIFT + QUOT_W;
   localparam int RCW = ADDR_W + 1;
   localparam logic [RCW-1:0] RECIP = RCW'((1 << RECIP_SHIFT) / SAMPLE_WORDS);
   localparam logic [IW-1:0] LAST_VOICE = IW'(VOICE_COUNT - 1);
   localparam logic [AW-1:0] LAST_WORD  = AW'(SAMPLE_WORDS - 1);

   typedef struct packed {
      logic [AW-1:0]    addr;
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] position;
   } voice_type;

   logic [SAMPLE_W-1:0] sample_mem [SAMPLE_WORDS];
   voice_type           voice_mem [VOICE_COUNT];

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [SAMPLE_W-1:0] acc_ff, acc_in;
   status_type          stat_ff, stat_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] mix_out_ff, mix_out_in;
   logic [STATUS_W-1:0] stat_out_ff, stat_out_in;
   logic [SLOT_W-1:0]   slot_out_ff, slot_out_in;
   logic [COUNT_W-1:0]  count_out_ff, count_out_in;

   voice_type           voice_q_ff;
   logic [SAMPLE_W-1:0] sample_q_ff;

   voice_type           vwr_data;
   logic                vwr_en;
   logic                smp_wr_en;
   logic [PW-1:0]       prod;
   logic [RW-1:0]       diff;
   logic [AW-1:0]       addr_next;
   logic [LEN_W-1:0]    pos_inc;
   logic                voice_done;
   logic [SAMPLE_W:0]   sum;

   assign prod       = PW'(rem_ff) * PW'(RECIP);
   assign diff       = RW'(rem_ff) - RW'(quot_ff) * RW'(SAMPLE_WORDS);
   assign addr_next  = (voice_q_ff.addr == LAST_WORD) ? '0 : voice_q_ff.addr + AW'(1);
   assign pos_inc    = voice_q_ff.position + LEN_W'(1);
   assign voice_done = (pos_inc >= voice_q_ff.length) || (pos_inc == '0);
   assign sum        = {acc_ff[SAMPLE_W-1], acc_ff} + {sample_q_ff[SAMPLE_W-1], sample_q_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      value_in     = value_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      stat_in      = stat_ff;
      slot_in      = slot_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      mix_out_in   = mix_out_ff;
      stat_out_in  = stat_out_ff;
      slot_out_in  = slot_out_ff;
      count_out_in = count_out_ff;
      vwr_en       = 1'b0;
      vwr_data     = voice_q_ff;
      smp_wr_en    = 1'b0;

      // drop the response once it transfers
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               rem_in   = req_chan.address;
               value_in = req_chan.sample_value;
               len_in   = req_chan.sound_length;
               step_in  = MOD_STEP_W'(MOD_STEPS - 1);
               acc_in   = '0;
               stat_in  = STAT_OK;
               slot_in  = '0;
               case (req_chan.command)
                  CMD_LOAD: begin
                     state_in = S_REDUCE;
                  end
                  CMD_QUEUE: begin
                     if (req_chan.sound_length == '0) begin
                        stat_in  = STAT_ZERO_LEN;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_REDUCE;
                     end
                  end
                  CMD_TICK: begin
                     state_in = S_TICK_SMP;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_REDUCE: begin
            // estimate the quotient by reciprocal, strip it, then correct by one depth
            if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
               quot_in = prod[RECIP_SHIFT +: QUOT_W];
            end else if (step_ff != '0) begin
               rem_in = diff[ADDR_W-1:0];
            end else if ({1'b0, rem_ff} >= RCW'(SAMPLE_WORDS)) begin
               rem_in = rem_ff - ADDR_W'(SAMPLE_WORDS);
            end
            step_in = step_ff - MOD_STEP_W'(1);
            if (step_ff == '0) begin
               state_in = (cmd_ff == CMD_LOAD) ? S_LOAD : S_SCAN;
            end
         end
         S_LOAD: begin
            smp_wr_en = 1'b1;
            state_in  = S_FINISH;
         end
         S_SCAN: begin
            if (!active_ff[idx_ff]) begin
               vwr_en            = 1'b1;
               vwr_data.addr     = rem_ff[AW-1:0];
               vwr_data.length   = len_ff;
               vwr_data.position = '0;
               active_in[idx_ff] = 1'b1;
               count_in          = count_ff + CW'(1);
               slot_in           = SLOT_W'(idx_ff);
               state_in          = S_FINISH;
            end else if (idx_ff == LAST_VOICE) begin
               stat_in  = STAT_NO_SLOT;
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_TICK_SMP: begin
            if (active_ff[idx_ff]) begin
               // advance the voice; the sample read is in flight
               vwr_en            = 1'b1;
               vwr_data.addr     = addr_next;
               vwr_data.position = voice_done ? '0 : pos_inc;
               if (voice_done) begin
                  active_in[idx_ff] = 1'b0;
                  count_in          = count_ff - CW'(1);
               end
               state_in = S_TICK_ACC;
            end else if (idx_ff == LAST_VOICE) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_TICK_ACC: begin
            if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
               acc_in = sum[SAMPLE_W] ? SAT_MIN : SAT_MAX;
            end else begin
               acc_in = sum[SAMPLE_W-1:0];
            end
            if (idx_ff == LAST_VOICE) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_TICK_SMP;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               mix_out_in   = acc_ff;
               stat_out_in  = stat_ff;
               slot_out_in  = slot_ff;
               count_out_in = COUNT_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      value_ff     <= value_in;
      len_ff       <= len_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      stat_ff      <= stat_in;
      slot_ff      <= slot_in;
      mix_out_ff   <= mix_out_in;
      stat_out_ff  <= stat_out_in;
      slot_out_ff  <= slot_out_in;
      count_out_ff <= count_out_in;
   end

   always_ff @(posedge clock) begin
      if (smp_wr_en) begin
         sample_mem[rem_ff[AW-1:0]] <= value_ff;
      end
      sample_q_ff <= sample_mem[voice_q_ff.addr];
   end

   always_ff @(posedge clock) begin
      if (vwr_en) begin
         voice_mem[idx_ff] <= vwr_data;
      end
      voice_q_ff <= voice_mem[idx_in];
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mixed_sample  = mix_out_ff;
   assign rsp_chan.status        = stat_out_ff;
   assign rsp_chan.voice_slot    = slot_out_ff;
   assign rsp_chan.active_voices = count_out_ff;

`ifndef SYNTH
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(active_ff)))
      else $error("active voice count out of step with voice flags");

   a_queue_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !active_ff[idx_ff]) |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("successful queue did not take a slot");

   a_reduce_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE && step_ff == '0) |=> 32'(rem_ff) < SAMPLE_WORDS)
      else $error("address reduction left a value beyond the memory");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STAT_OK) |->
         (rsp_chan.voice_slot == '0 && rsp_chan.mixed_sample == '0))
      else $error("error response carries slot or sample data");
`endif

endmodule
